// File: rtl/core/llp_pkg.sv
package llp_pkg;

	// Default number of entries on the parse stack.
	localparam int STACK_DEPTH_DEF = 64;

	// Grammar symbols as held on the parse stack.
	typedef enum logic [3:0] {
		SYM_END   = 4'd0,
		SYM_E     = 4'd1,
		SYM_EP    = 4'd2,
		SYM_T     = 4'd3,
		SYM_TP    = 4'd4,
		SYM_F     = 4'd5,
		SYM_A     = 4'd6,
		SYM_PLUS  = 4'd7,
		SYM_MINUS = 4'd8,
		SYM_STAR  = 4'd9,
		SYM_SLASH = 4'd10,
		SYM_LPAR  = 4'd11,
		SYM_RPAR  = 4'd12
	} sym_t;

	// Parse table columns; terminal columns line up with SYM_A onward.
	typedef enum logic [3:0] {
		COL_A       = 4'd0,
		COL_PLUS    = 4'd1,
		COL_MINUS   = 4'd2,
		COL_STAR    = 4'd3,
		COL_SLASH   = 4'd4,
		COL_LPAR    = 4'd5,
		COL_RPAR    = 4'd6,
		COL_END     = 4'd7,
		COL_UNKNOWN = 4'd8
	} col_t;

	// Productions selected by the parse table.
	typedef enum logic [3:0] {
		RULE_NONE  = 4'd0,
		RULE_EPS   = 4'd1,
		RULE_TE    = 4'd2,
		RULE_PLUS  = 4'd3,
		RULE_MINUS = 4'd4,
		RULE_FT    = 4'd5,
		RULE_STAR  = 4'd6,
		RULE_SLASH = 4'd7,
		RULE_PAREN = 4'd8,
		RULE_A     = 4'd9
	} rule_t;

	typedef enum logic [1:0] {
		VERDICT_PENDING = 2'd0,
		VERDICT_ACCEPT  = 2'd1,
		VERDICT_REJECT  = 2'd2
	} verdict_t;

	// Outcome of examining the top of the stack against the current byte.
	typedef enum logic [2:0] {
		ACT_REJECT = 3'd0,
		ACT_ACCEPT = 3'd1,
		ACT_MATCH  = 3'd2,
		ACT_EPS    = 3'd3,
		ACT_EXPAND = 3'd4
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_START = 3'd1,
		ST_READ  = 3'd2,
		ST_EVAL  = 3'd3,
		ST_PUSH  = 3'd4,
		ST_DONE  = 3'd5
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic start_check;
		logic read;
		logic set_accept;
		logic set_reject;
		logic pop;
		logic expand;
		logic push;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic go;
		act_t act;
		logic push_last;
		logic out_free;
	} stat_t;

	// Maps a raw byte onto a table column.
	function automatic col_t classify(input logic [7:0] b);
		col_t c;
		case (b)
			8'h61:   c = COL_A;
			8'h2B:   c = COL_PLUS;
			8'h2D:   c = COL_MINUS;
			8'h2A:   c = COL_STAR;
			8'h2F:   c = COL_SLASH;
			8'h28:   c = COL_LPAR;
			8'h29:   c = COL_RPAR;
			8'h24:   c = COL_END;
			default: c = COL_UNKNOWN;
		endcase
		return c;
	endfunction

	// The LL(1) parse table for the nonterminal rows.
	function automatic rule_t table_rule(input logic [3:0] top, input col_t col);
		rule_t r;
		r = RULE_NONE;
		case (top)
			SYM_E: begin
				if (col == COL_A || col == COL_LPAR) r = RULE_TE;
			end
			SYM_EP: begin
				if (col == COL_PLUS) r = RULE_PLUS;
				else if (col == COL_MINUS) r = RULE_MINUS;
				else if (col == COL_RPAR || col == COL_END) r = RULE_EPS;
			end
			SYM_T: begin
				if (col == COL_A || col == COL_LPAR) r = RULE_FT;
			end
			SYM_TP: begin
				if (col == COL_STAR) r = RULE_STAR;
				else if (col == COL_SLASH) r = RULE_SLASH;
				else if (col == COL_PLUS || col == COL_MINUS || col == COL_RPAR ||
						col == COL_END) r = RULE_EPS;
			end
			SYM_F: begin
				if (col == COL_A) r = RULE_A;
				else if (col == COL_LPAR) r = RULE_PAREN;
			end
			default: r = RULE_NONE;
		endcase
		return r;
	endfunction

	// Number of symbols a production pushes.
	function automatic logic [1:0] rule_len(input rule_t r);
		logic [1:0] n;
		case (r)
			RULE_TE, RULE_FT: n = 2'd2;
			RULE_PLUS, RULE_MINUS, RULE_STAR, RULE_SLASH, RULE_PAREN: n = 2'd3;
			RULE_A: n = 2'd1;
			default: n = 2'd0;
		endcase
		return n;
	endfunction

	// Symbol k of a production in push order, last symbol of the body first.
	function automatic sym_t rule_push(input rule_t r, input logic [1:0] k);
		sym_t s;
		s = SYM_END;
		case (r)
			RULE_TE, RULE_PLUS, RULE_MINUS: begin
				if (k == 2'd0) s = SYM_EP;
				else if (k == 2'd1) s = SYM_T;
				else if (r == RULE_PLUS) s = SYM_PLUS;
				else s = SYM_MINUS;
			end
			RULE_FT, RULE_STAR, RULE_SLASH: begin
				if (k == 2'd0) s = SYM_TP;
				else if (k == 2'd1) s = SYM_F;
				else if (r == RULE_STAR) s = SYM_STAR;
				else s = SYM_SLASH;
			end
			RULE_PAREN: begin
				if (k == 2'd0) s = SYM_RPAR;
				else if (k == 2'd1) s = SYM_E;
				else s = SYM_LPAR;
			end
			RULE_A: s = SYM_A;
			default: s = SYM_END;
		endcase
		return s;
	endfunction

endpackage

// File: rtl/core/llp_ctrl.sv
module llp_ctrl import llp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  in_stall
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_START;
			end
			ST_START: begin
				state_d = stat.go ? ST_READ : ST_DONE;
			end
			ST_READ: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				case (stat.act)
					ACT_EPS:    state_d = ST_READ;
					ACT_EXPAND: state_d = ST_PUSH;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_PUSH: begin
				if (stat.push_last) state_d = ST_READ;
			end
			ST_DONE: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Command decode.
	always_comb begin
		cmd = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE:  cmd.load = in_valid;
			ST_START: cmd.start_check = 1'b1;
			ST_READ:  cmd.read = 1'b1;
			ST_EVAL: begin
				case (stat.act)
					ACT_ACCEPT: cmd.set_accept = 1'b1;
					ACT_MATCH:  cmd.pop = 1'b1;
					ACT_EPS:    cmd.pop = 1'b1;
					ACT_EXPAND: cmd.expand = 1'b1;
					default:    cmd.set_reject = 1'b1;
				endcase
			end
			ST_PUSH:  cmd.push = 1'b1;
			ST_DONE:  cmd.out_load = stat.out_free;
			default:  cmd = '0;
		endcase
	end

endmodule

// File: rtl/core/llp_dp.sv
module llp_dp import llp_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output stat_t      stat,
	input  logic       restart,
	input  logic [7:0] symbol,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [1:0] verdict,
	output logic [6:0] depth
);

	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int A_W  = $clog2(STACK_DEPTH);

	logic [3:0]      stack_mem [STACK_DEPTH];
	logic [SP_W-1:0] sp_q;
	verdict_t        status_q;
	logic            e1_written_q;
	col_t            col_q;
	logic [3:0]      rd_data_q;
	logic [A_W-1:0]  rd_idx_q;
	rule_t           rule_q;
	logic [1:0]      k_q;
	logic            out_valid_q;
	verdict_t        verdict_q;
	logic [6:0]      depth_q;

	logic [A_W-1:0]  rd_addr;
	logic [A_W-1:0]  wr_addr;
	logic [3:0]      top_sym;
	rule_t           rule_cur;
	logic [SP_W:0]   grow;
	act_t            act;

	assign rd_addr = A_W'(sp_q - SP_W'(1));
	assign wr_addr = A_W'(sp_q);

	// Entry 0 is never written and always reads as the end marker; entry 1 reads as E
	// until a push overwrites it after the last restart.
	always_comb begin
		if (rd_idx_q == '0) begin
			top_sym = SYM_END;
		end else if (rd_idx_q == A_W'(1) && !e1_written_q) begin
			top_sym = SYM_E;
		end else begin
			top_sym = rd_data_q;
		end
	end

	// Decide what the top of the stack does with the current byte.
	always_comb begin
		rule_cur = table_rule(top_sym, col_q);
		grow = {1'b0, sp_q} + (SP_W+1)'(rule_len(rule_cur)) - (SP_W+1)'(1);
		if (sp_q == '0 || sp_q > SP_W'(STACK_DEPTH)) begin
			act = ACT_REJECT;
		end else if (top_sym == SYM_END) begin
			act = (col_q == COL_END) ? ACT_ACCEPT : ACT_REJECT;
		end else if (top_sym >= SYM_A) begin
			act = (col_q != COL_END && top_sym == 4'(SYM_A) + 4'(col_q)) ?
				ACT_MATCH : ACT_REJECT;
		end else if (rule_cur == RULE_NONE) begin
			act = ACT_REJECT;
		end else if (rule_cur == RULE_EPS) begin
			act = ACT_EPS;
		end else if (grow > (SP_W+1)'(STACK_DEPTH)) begin
			act = ACT_REJECT;
		end else begin
			act = ACT_EXPAND;
		end
	end

	// Status back to the controller.
	always_comb begin
		stat.go        = (status_q == VERDICT_PENDING) && (col_q != COL_UNKNOWN);
		stat.act       = act;
		stat.push_last = (k_q == rule_len(rule_q) - 2'd1);
		stat.out_free  = !out_valid_q || !out_stall;
	end

	// Symbol stack memory with a registered read port.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stack_mem[wr_addr] <= rule_push(rule_q, k_q);
		end
		if (cmd.read) begin
			rd_data_q <= stack_mem[rd_addr];
			rd_idx_q  <= rd_addr;
		end
	end

	// Stack pointer, verdict and the entry 1 written flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q         <= SP_W'(2);
			status_q     <= VERDICT_PENDING;
			e1_written_q <= 1'b0;
		end else begin
			if (cmd.load && restart) begin
				sp_q         <= SP_W'(2);
				status_q     <= VERDICT_PENDING;
				e1_written_q <= 1'b0;
			end
			if (cmd.start_check && status_q == VERDICT_PENDING && col_q == COL_UNKNOWN) begin
				status_q <= VERDICT_REJECT;
			end
			if (cmd.set_accept) status_q <= VERDICT_ACCEPT;
			if (cmd.set_reject) status_q <= VERDICT_REJECT;
			if (cmd.pop || cmd.expand) sp_q <= sp_q - SP_W'(1);
			if (cmd.push) begin
				sp_q <= sp_q + SP_W'(1);
				if (sp_q == SP_W'(1)) e1_written_q <= 1'b1;
			end
		end
	end

	// Byte column, selected production and push counter.
	always_ff @(posedge clk) begin
		if (cmd.load) col_q <= classify(symbol);
		if (cmd.expand) begin
			rule_q <= rule_cur;
			k_q    <= 2'd0;
		end else if (cmd.push) begin
			k_q <= k_q + 2'd1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			verdict_q <= status_q;
			depth_q   <= 7'(sp_q);
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;
	assign depth     = depth_q;

endmodule

// File: rtl/core/ll1_expression_parser_top.sv
// LL(1) predictive parser for the expression grammar over a, + - * / ( ) and $.
// Input channel: in_valid / in_stall with fields restart and symbol, one byte
// per request. restart reinitializes the stack to end marker and E before the
// byte is parsed. Output channel: out_valid / out_stall with verdict (0 pending,
// 1 accepted, 2 rejected) and depth (symbols left on the stack), one result per
// request, in order.
// Sequence: each byte passes a start check, then a stack read and an evaluation
// for each parse step, a push state per symbol of each expansion, and a final
// load of the output register. The stack memory takes one read or one write
// per cycle. Once a verdict is final, a byte goes from the start check straight
// to the output register until the next restart.
// Reset clears the verdict to pending and leaves the stack as end marker and E;
// no clearing pass is needed. The result sits in an output register, so the
// block finishes its next byte while the receiver stalls, then holds in_stall
// high until that register frees up.
module ll1_expression_parser_top import llp_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       restart,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] verdict,
	output logic [6:0] depth
);

	cmd_t  cmd;
	stat_t stat;

	llp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	llp_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.restart   (restart),
		.symbol    (symbol),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.verdict   (verdict),
		.depth     (depth)
	);

	// An accepted string leaves only the end marker on the stack.
	a_accept_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && verdict == VERDICT_ACCEPT) |-> (depth == 7'd1))
		else $error("accepted result with depth other than one");

	// The block is busy in the cycle after it takes a request.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request taken without going busy");

	// Only defined verdict codes leave the block.
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict == VERDICT_PENDING || verdict == VERDICT_ACCEPT ||
			verdict == VERDICT_REJECT))
		else $error("undefined verdict code");

endmodule

// File: sim/ll1_expression_parser_top_tb.sv
`timescale 1ns / 100ps

module ll1_expression_parser_top_tb;
	import llp_pkg::*;

	localparam int DEPTH = STACK_DEPTH_DEF;
	localparam int TOTAL_ITEMS = 1900;
	localparam int MAX_LEN = 70;
	localparam int SETTLE_CYCLES = 50;

	// Input bytes the grammar knows.
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_END   = 8'h24;

	typedef struct {
		verdict_t   verdict;
		logic [6:0] depth;
	} parse_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       restart = 1'b0;
	logic [7:0] symbol = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] verdict;
	logic [6:0] depth;

	// Shadow copy of the parse state.
	sym_t     shadow_stack [DEPTH];
	int       shadow_sp;
	verdict_t shadow_status;

	parse_result_t parse_results_q[$];
	parse_result_t want;

	int  errors = 0;
	int  n_sent = 0;
	int  live_bytes = 0;
	int  n_checked = 0;
	int  n_accepted = 0;
	int  n_rejected = 0;
	int  max_depth = 0;
	bit  idle_en = 1'b1;
	bit  hold_req = 1'b0;
	int  hold_len = 0;

	ll1_expression_parser_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.restart   (restart),
		.symbol    (symbol),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.verdict   (verdict),
		.depth     (depth)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit, far above the slowest legal run.
	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Parser predictor.

	function automatic col_t byte_column(input logic [7:0] b);
		case (b)
			CH_A:     return COL_A;
			CH_PLUS:  return COL_PLUS;
			CH_MINUS: return COL_MINUS;
			CH_STAR:  return COL_STAR;
			CH_SLASH: return COL_SLASH;
			CH_LPAR:  return COL_LPAR;
			CH_RPAR:  return COL_RPAR;
			CH_END:   return COL_END;
			default:  return COL_UNKNOWN;
		endcase
	endfunction

	// Looks up the production for a nonterminal and column. The body comes back
	// in push order; a length of zero means the epsilon production.
	function automatic bit derive(input sym_t nt, input col_t c, output sym_t body [3],
			output int len);
		bit found;
		found = 1'b0;
		len = 0;
		body = '{SYM_END, SYM_END, SYM_END};
		case (nt)
			SYM_E, SYM_T: begin
				if (c == COL_A || c == COL_LPAR) begin
					found = 1'b1;
					len = 2;
					if (nt == SYM_E)
						body = '{SYM_EP, SYM_T, SYM_END};
					else
						body = '{SYM_TP, SYM_F, SYM_END};
				end
			end
			SYM_EP: begin
				if (c == COL_PLUS || c == COL_MINUS) begin
					found = 1'b1;
					len = 3;
					body = '{SYM_EP, SYM_T, (c == COL_PLUS) ? SYM_PLUS : SYM_MINUS};
				end else if (c == COL_RPAR || c == COL_END) begin
					found = 1'b1;
				end
			end
			SYM_TP: begin
				if (c == COL_STAR || c == COL_SLASH) begin
					found = 1'b1;
					len = 3;
					body = '{SYM_TP, SYM_F, (c == COL_STAR) ? SYM_STAR : SYM_SLASH};
				end else if (c == COL_PLUS || c == COL_MINUS || c == COL_RPAR ||
						c == COL_END) begin
					found = 1'b1;
				end
			end
			SYM_F: begin
				if (c == COL_A) begin
					found = 1'b1;
					len = 1;
					body = '{SYM_A, SYM_END, SYM_END};
				end else if (c == COL_LPAR) begin
					found = 1'b1;
					len = 3;
					body = '{SYM_RPAR, SYM_E, SYM_LPAR};
				end
			end
			default: found = 1'b0;
		endcase
		return found;
	endfunction

	// Expands the stack until the byte is matched, accepted or rejected.
	function automatic verdict_t consume_column(input col_t c);
		sym_t top;
		sym_t body [3];
		int   len;
		if (c == COL_UNKNOWN)
			return VERDICT_REJECT;
		for (int g = 0; g < 4 * DEPTH + 8; g++) begin
			if (shadow_sp == 0 || shadow_sp > DEPTH)
				return VERDICT_REJECT;
			top = shadow_stack[shadow_sp - 1];
			if (top == SYM_END)
				return (c == COL_END) ? VERDICT_ACCEPT : VERDICT_REJECT;
			if (top >= SYM_A) begin
				if (c != COL_END && int'(top) == int'(SYM_A) + int'(c)) begin
					shadow_sp--;
					return VERDICT_PENDING;
				end
				return VERDICT_REJECT;
			end
			if (!derive(top, c, body, len))
				return VERDICT_REJECT;
			if (len == 0) begin
				shadow_sp--;
			end else begin
				if (shadow_sp - 1 + len > DEPTH)
					return VERDICT_REJECT;
				shadow_sp--;
				for (int k = 0; k < len; k++) begin
					shadow_stack[shadow_sp] = body[k];
					shadow_sp++;
				end
			end
		end
		return VERDICT_REJECT;
	endfunction

	function automatic void init_shadow();
		foreach (shadow_stack[i])
			shadow_stack[i] = SYM_END;
		shadow_stack[1] = SYM_E;
		shadow_sp = 2;
		shadow_status = VERDICT_PENDING;
	endfunction

	function automatic parse_result_t parse_step(input bit rst, input logic [7:0] b);
		parse_result_t r;
		if (rst)
			init_shadow();
		if (shadow_status == VERDICT_PENDING)
			shadow_status = consume_column(byte_column(b));
		r.verdict = shadow_status;
		r.depth = shadow_sp[6:0];
		return r;
	endfunction

	// Idle gaps: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_en || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_known();
		case ($urandom_range(0, 7))
			0: return CH_A;
			1: return CH_PLUS;
			2: return CH_MINUS;
			3: return CH_STAR;
			4: return CH_SLASH;
			5: return CH_LPAR;
			6: return CH_RPAR;
			default: return CH_END;
		endcase
	endfunction

	// Offers one request after a random gap and records the predicted result.
	task automatic send_symbol(input bit rst, input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		restart <= rst;
		symbol <= b;
		do @(posedge clk); while (in_stall !== 1'b0);
		n_sent++;
		if (rst || shadow_status == VERDICT_PENDING)
			live_bytes++;
		parse_results_q.insert(parse_results_q.size(), parse_step(rst, b));
	endtask

	// Sends a byte string, restarting the parser on its first byte.
	task automatic send_string(input logic [7:0] q[$]);
		foreach (q[i])
			send_symbol(i == 0, q[i]);
	endtask

	// Stops offering and waits until every expected result has arrived.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (parse_results_q.size() == 0);
	endtask

	// Random expression strings from the grammar.
	task automatic gen_expr(ref logic [7:0] q[$], input int lvl, input bit deep);
		int n;
		n = 0;
		gen_term(q, lvl, deep);
		while (!deep && q.size() < MAX_LEN && n < 3 && $urandom_range(0, 99) < 35) begin
			q.insert(q.size(), $urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
			gen_term(q, lvl, deep);
			n++;
		end
	endtask

	task automatic gen_term(ref logic [7:0] q[$], input int lvl, input bit deep);
		int n;
		n = 0;
		gen_factor(q, lvl, deep);
		while (!deep && q.size() < MAX_LEN && n < 3 && $urandom_range(0, 99) < 35) begin
			q.insert(q.size(), $urandom_range(0, 1) ? CH_STAR : CH_SLASH);
			gen_factor(q, lvl, deep);
			n++;
		end
	endtask

	task automatic gen_factor(ref logic [7:0] q[$], input int lvl, input bit deep);
		if (lvl > 0 && q.size() < MAX_LEN && $urandom_range(0, 99) < (deep ? 95 : 30)) begin
			q.insert(q.size(), CH_LPAR);
			gen_expr(q, lvl - 1, deep);
			q.insert(q.size(), CH_RPAR);
		end else begin
			q.insert(q.size(), CH_A);
		end
	endtask

	// Each result is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (parse_results_q.size() == 0) begin
				$error("result with no request outstanding: verdict %0d depth %0d",
					verdict, depth);
				errors++;
			end else begin
				want = parse_results_q.pop_front();
				n_checked++;
				if (verdict !== want.verdict) begin
					$error("verdict mismatch: expected %0d, actual %0d", want.verdict, verdict);
					errors++;
				end
				if (depth !== want.depth) begin
					$error("depth mismatch: expected %0d, actual %0d", want.depth, depth);
					errors++;
				end
				if (want.verdict == VERDICT_ACCEPT) n_accepted++;
				if (want.verdict == VERDICT_REJECT) n_rejected++;
				if (int'(want.depth) > max_depth) max_depth = int'(want.depth);
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when a test asks for one.
	initial begin : receiver
		int n;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (hold_len) @(negedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (idle_en && $urandom_range(0, 99) < 25) begin
				n = pick_gap() + 1;
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Operators, extremes of the byte, special cases.
	task automatic test_directed();
		// A minimal string is accepted with only the end marker left.
		send_symbol(1'b1, CH_A);
		send_symbol(1'b0, CH_END);
		// The verdict is final, so this byte is ignored.
		send_symbol(1'b0, CH_END);
		// An empty string hits an empty table entry.
		send_symbol(1'b1, CH_END);
		// Unknown bytes reject and leave the stack alone.
		send_symbol(1'b1, 8'h00);
		send_symbol(1'b1, 8'hFF);
		// Every operator and both parentheses in one accepted string.
		send_string('{CH_LPAR, CH_A, CH_PLUS, CH_A, CH_RPAR, CH_STAR, CH_A, CH_MINUS,
			CH_A, CH_SLASH, CH_A, CH_END});
		// A string may not begin with a closing parenthesis or an operator.
		send_symbol(1'b1, CH_RPAR);
		send_symbol(1'b1, CH_PLUS);
		// Two operands in a row.
		send_symbol(1'b1, CH_A);
		send_symbol(1'b0, CH_A);
		// A restart in the middle of a string discards it.
		send_symbol(1'b1, CH_LPAR);
		send_symbol(1'b1, CH_A);
		send_symbol(1'b0, CH_END);
		drain();
	endtask

	// Nesting right up to the stack limit, then one level past it.
	task automatic test_stack_limit();
		logic [7:0] q[$];
		q = {};
		repeat (20) q.insert(q.size(), CH_LPAR);
		q.insert(q.size(), CH_A);
		repeat (20) q.insert(q.size(), CH_RPAR);
		q.insert(q.size(), CH_END);
		send_string(q);
		q = {};
		repeat (21) q.insert(q.size(), CH_LPAR);
		q.insert(q.size(), CH_A);
		send_string(q);
		drain();
	endtask

	// The receiver holds off while the sender keeps offering back to back.
	task automatic test_receiver_holdoff();
		logic [7:0] q[$];
		drain();
		idle_en = 1'b0;
		hold_len = 300;
		hold_req = 1'b1;
		repeat (4) begin
			q = {};
			gen_expr(q, 2, 1'b0);
			q.insert(q.size(), CH_END);
			send_string(q);
		end
		drain();
		idle_en = 1'b1;
	endtask

	// Mostly well-formed strings with random content, the rest broken or noise.
	task automatic test_random_strings();
		logic [7:0] q[$];
		int kind;
		int n;
		int pos;
		int seqs;
		seqs = 0;
		while (n_sent < TOTAL_ITEMS) begin
			idle_en = ($urandom_range(0, 99) >= 15);
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				n = $urandom_range(1, 8);
				repeat (n)
					send_symbol($urandom_range(0, 3) == 0,
						$urandom_range(0, 1) ? pick_known() : 8'($urandom_range(0, 255)));
			end else begin
				q = {};
				if (kind < 12)
					gen_expr(q, $urandom_range(15, 23), 1'b1);
				else
					gen_expr(q, $urandom_range(0, 4), 1'b0);
				q.insert(q.size(), CH_END);
				if ($urandom_range(0, 99) < 20) begin
					pos = $urandom_range(0, q.size() - 1);
					case ($urandom_range(0, 3))
						0: q[pos] = 8'($urandom_range(0, 255));
						1: q.pop_back();
						2: q.insert(pos, pick_known());
						default: q = q[0:pos];
					endcase
				end
				foreach (q[i])
					send_symbol(i == 0 || $urandom_range(0, 99) == 0, q[i]);
			end
			seqs++;
			// Now and then the sender pauses until the block has emptied.
			if (seqs % 30 == 0)
				drain();
		end
		drain();
		idle_en = 1'b1;
	endtask

	initial begin
		init_shadow();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_stack_limit();
		test_receiver_holdoff();
		test_random_strings();

		@(negedge clk);
		in_valid <= 1'b0;
		wait (parse_results_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests, %0d of them live, in %0d results: %0d accepted, %0d rejected.",
			n_sent, live_bytes, n_checked, n_accepted, n_rejected);
		$display("Deepest stack seen %0d; overflow, hold-off and drain pauses included.",
			max_depth);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
